// File: rtl/stc_pkg.sv
`default_nettype none

package stc_pkg;

  // Field widths of the command and result beats.
  localparam int CMD_W  = 2;
  localparam int MIN_W  = 11;
  localparam int TEMP_W = 16;

  // Width of the microprogram counter; the control store has 2**UPC_W words.
  localparam int UPC_W = 4;

  // 70.0 degrees in Q8.8, used when the schedule holds no entry.
  localparam logic signed [TEMP_W-1:0] DEFAULT_SETPOINT = 16'sh4600;

  typedef logic [UPC_W-1:0] upc_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_EVAL  = 2'd2
  } cmd_e;

  // One schedule entry as stored in the entry memory.
  typedef struct packed {
    logic        [MIN_W-1:0]  minute;
    logic signed [TEMP_W-1:0] target;
  } entry_t;

  typedef enum logic [2:0] {
    IDX_HOLD      = 3'd0,
    IDX_ZERO      = 3'd1,
    IDX_CNT       = 3'd2,
    IDX_INC       = 3'd3,
    IDX_SHIFT_DEC = 3'd4
  } idx_op_e;

  typedef enum logic {
    RD_IDX    = 1'b0,
    RD_IDX_M1 = 1'b1
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_NONE  = 2'd0,
    WR_SHIFT = 2'd1,
    WR_NEW   = 2'd2
  } wr_op_e;

  typedef enum logic [1:0] {
    CNT_HOLD  = 2'd0,
    CNT_CLEAR = 2'd1,
    CNT_INC   = 2'd2
  } cnt_op_e;

  typedef enum logic [3:0] {
    C_ACCEPT   = 4'd0,
    C_CLEAR    = 4'd1,
    C_ADD      = 4'd2,
    C_EVAL     = 4'd3,
    C_FULL     = 4'd4,
    C_EMPTY    = 4'd5,
    C_SCAN_END = 4'd6,
    C_SHIFT    = 4'd7,
    C_OUT_BUSY = 4'd8
  } cond_e;

  typedef enum logic [2:0] {
    J_NEXT   = 3'd0,
    J_GOTO   = 3'd1,
    J_IF     = 3'd2,
    J_UNLESS = 3'd3,
    J_HOLD   = 3'd4
  } jmp_e;

  // Datapath part of a control word.
  typedef struct packed {
    logic    accept;
    idx_op_e idx_op;
    rd_sel_e rd_sel;
    wr_op_e  wr_op;
    cnt_op_e cnt_op;
    logic    sp_take;
    logic    out_load;
  } dp_ctrl_t;

  // Whole control word: datapath controls plus the branch.
  typedef struct packed {
    dp_ctrl_t dp;
    jmp_e     jmp;
    cond_e    cond;
    upc_t     target;
  } uword_t;

  // Status flags the datapath offers to the sequencer's branch logic.
  typedef struct packed {
    logic accept;
    logic is_clear;
    logic is_add;
    logic is_eval;
    logic full;
    logic empty;
    logic scan_end;
    logic shift;
    logic out_busy;
  } flags_t;

endpackage

`default_nettype wire

// File: rtl/stc_in_if.sv
`default_nettype none

interface stc_in_if;
  logic                                     valid;
  logic                                     ready;
  logic        [stc_pkg::CMD_W-1:0]         cmd;
  logic        [stc_pkg::MIN_W-1:0]         minute_of_day;
  logic signed [stc_pkg::TEMP_W-1:0]        temperature;

  modport source (output valid, cmd, minute_of_day, temperature, input ready);
  modport sink   (input valid, cmd, minute_of_day, temperature, output ready);
endinterface

`default_nettype wire

// File: rtl/stc_out_if.sv
`default_nettype none

interface stc_out_if;
  logic                              valid;
  logic                              ready;
  logic                              heater_on;
  logic                              heater_changed;
  logic signed [stc_pkg::TEMP_W-1:0] setpoint_used;
  logic                              schedule_empty;

  modport source (output valid, heater_on, heater_changed, setpoint_used, schedule_empty,
                  input ready);
  modport sink   (input valid, heater_on, heater_changed, setpoint_used, schedule_empty,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/stc_sequencer.sv
`default_nettype none

module stc_sequencer (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire stc_pkg::flags_t   flags,
  output stc_pkg::dp_ctrl_t      ctrl
);

  // Microprogram addresses.
  localparam stc_pkg::upc_t S_WAIT     = stc_pkg::upc_t'(0);
  localparam stc_pkg::upc_t S_DISPATCH = stc_pkg::upc_t'(1);
  localparam stc_pkg::upc_t S_IS_ADD   = stc_pkg::upc_t'(2);
  localparam stc_pkg::upc_t S_IS_EVAL  = stc_pkg::upc_t'(3);
  localparam stc_pkg::upc_t S_EV_INIT  = stc_pkg::upc_t'(4);
  localparam stc_pkg::upc_t S_EV_SCAN  = stc_pkg::upc_t'(5);
  localparam stc_pkg::upc_t S_EV_OUT   = stc_pkg::upc_t'(6);
  localparam stc_pkg::upc_t S_CLEAR    = stc_pkg::upc_t'(7);
  localparam stc_pkg::upc_t S_AD_INIT  = stc_pkg::upc_t'(8);
  localparam stc_pkg::upc_t S_AD_SHIFT = stc_pkg::upc_t'(9);
  localparam stc_pkg::upc_t S_AD_PUT   = stc_pkg::upc_t'(10);

  // Control store. Unused words return to the wait step.
  function automatic stc_pkg::uword_t ucode(input stc_pkg::upc_t a);
    stc_pkg::uword_t w;
    w        = '0;
    w.jmp    = stc_pkg::J_GOTO;
    w.cond   = stc_pkg::C_ACCEPT;
    w.target = S_WAIT;
    case (a)
      S_WAIT: begin
        w.dp.accept = 1'b1;
        w.jmp       = stc_pkg::J_UNLESS;
        w.cond      = stc_pkg::C_ACCEPT;
        w.target    = S_WAIT;
      end
      S_DISPATCH: begin
        w.jmp    = stc_pkg::J_IF;
        w.cond   = stc_pkg::C_CLEAR;
        w.target = S_CLEAR;
      end
      S_IS_ADD: begin
        w.jmp    = stc_pkg::J_IF;
        w.cond   = stc_pkg::C_ADD;
        w.target = S_AD_INIT;
      end
      S_IS_EVAL: begin
        w.jmp    = stc_pkg::J_UNLESS;
        w.cond   = stc_pkg::C_EVAL;
        w.target = S_WAIT;
      end
      S_EV_INIT: begin
        w.dp.idx_op = stc_pkg::IDX_ZERO;
        w.dp.rd_sel = stc_pkg::RD_IDX;
        w.jmp       = stc_pkg::J_IF;
        w.cond      = stc_pkg::C_EMPTY;
        w.target    = S_EV_OUT;
      end
      S_EV_SCAN: begin
        w.dp.idx_op  = stc_pkg::IDX_INC;
        w.dp.rd_sel  = stc_pkg::RD_IDX;
        w.dp.sp_take = 1'b1;
        w.jmp        = stc_pkg::J_UNLESS;
        w.cond       = stc_pkg::C_SCAN_END;
        w.target     = S_EV_SCAN;
      end
      S_EV_OUT: begin
        w.dp.out_load = 1'b1;
        w.jmp         = stc_pkg::J_HOLD;
        w.cond        = stc_pkg::C_OUT_BUSY;
        w.target      = S_WAIT;
      end
      S_CLEAR: begin
        w.dp.cnt_op = stc_pkg::CNT_CLEAR;
        w.jmp       = stc_pkg::J_GOTO;
        w.target    = S_WAIT;
      end
      S_AD_INIT: begin
        w.dp.idx_op = stc_pkg::IDX_CNT;
        w.dp.rd_sel = stc_pkg::RD_IDX_M1;
        w.jmp       = stc_pkg::J_IF;
        w.cond      = stc_pkg::C_FULL;
        w.target    = S_WAIT;
      end
      S_AD_SHIFT: begin
        w.dp.idx_op = stc_pkg::IDX_SHIFT_DEC;
        w.dp.rd_sel = stc_pkg::RD_IDX_M1;
        w.dp.wr_op  = stc_pkg::WR_SHIFT;
        w.jmp       = stc_pkg::J_HOLD;
        w.cond      = stc_pkg::C_SHIFT;
        w.target    = S_AD_PUT;
      end
      S_AD_PUT: begin
        w.dp.wr_op  = stc_pkg::WR_NEW;
        w.dp.cnt_op = stc_pkg::CNT_INC;
        w.jmp       = stc_pkg::J_GOTO;
        w.target    = S_WAIT;
      end
      default: begin
        w.jmp    = stc_pkg::J_GOTO;
        w.target = S_WAIT;
      end
    endcase
    return w;
  endfunction

  stc_pkg::upc_t   upc_r;
  stc_pkg::upc_t   upc_nxt;
  stc_pkg::uword_t uw;
  logic            cond_hit;

  assign uw   = ucode(upc_r);
  assign ctrl = uw.dp;

  always_comb begin
    case (uw.cond)
      stc_pkg::C_ACCEPT:   cond_hit = flags.accept;
      stc_pkg::C_CLEAR:    cond_hit = flags.is_clear;
      stc_pkg::C_ADD:      cond_hit = flags.is_add;
      stc_pkg::C_EVAL:     cond_hit = flags.is_eval;
      stc_pkg::C_FULL:     cond_hit = flags.full;
      stc_pkg::C_EMPTY:    cond_hit = flags.empty;
      stc_pkg::C_SCAN_END: cond_hit = flags.scan_end;
      stc_pkg::C_SHIFT:    cond_hit = flags.shift;
      stc_pkg::C_OUT_BUSY: cond_hit = flags.out_busy;
      default:             cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    case (uw.jmp)
      stc_pkg::J_NEXT:   upc_nxt = upc_r + stc_pkg::upc_t'(1);
      stc_pkg::J_GOTO:   upc_nxt = uw.target;
      stc_pkg::J_IF:     upc_nxt = cond_hit ? uw.target : upc_r + stc_pkg::upc_t'(1);
      stc_pkg::J_UNLESS: upc_nxt = cond_hit ? upc_r + stc_pkg::upc_t'(1) : uw.target;
      stc_pkg::J_HOLD:   upc_nxt = cond_hit ? upc_r : uw.target;
      default:           upc_nxt = S_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= S_WAIT;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  // An accepted command always moves on to decoding in the next cycle.
  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    flags.accept |=> upc_r == S_DISPATCH)
    else $error("accepted command did not reach dispatch");

endmodule

`default_nettype wire

// File: rtl/stc_datapath.sv
`default_nettype none

module stc_datapath #(
  parameter int MAX_ENTRIES = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  stc_in_if.sink                 in_ch,
  stc_out_if.source              out_ch,
  input  wire stc_pkg::dp_ctrl_t ctrl,
  output stc_pkg::flags_t        flags
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  // Entry memory: one write and one registered read per cycle.
  stc_pkg::entry_t mem [MAX_ENTRIES];
  stc_pkg::entry_t rd_r;

  logic        [stc_pkg::CMD_W-1:0]  cmd_r;
  logic        [stc_pkg::MIN_W-1:0]  min_r;
  logic signed [stc_pkg::TEMP_W-1:0] temp_r;
  logic signed [stc_pkg::TEMP_W-1:0] sp_r;
  logic        [IDX_W-1:0]           idx_r;
  logic        [IDX_W-1:0]           idx_nxt;
  logic        [IDX_W-1:0]           rd_addr;
  logic        [CNT_W-1:0]           cnt_r;
  logic        [CNT_W-1:0]           cnt_nxt;
  logic        [CNT_W:0]             idx_inc;

  logic last_valid_r, last_valid_nxt;
  logic last_on_r;
  logic out_valid_r, out_valid_nxt;
  logic heater_on_r, heater_changed_r, empty_r;
  logic signed [stc_pkg::TEMP_W-1:0] setpoint_r;

  logic fire, out_free, ld, gt, take, shift, empty, on, changed;
  logic wr_en;
  logic signed [stc_pkg::TEMP_W-1:0] sp_sel;
  stc_pkg::entry_t wr_data;

  assign fire     = ctrl.accept && in_ch.valid;
  assign out_free = !out_valid_r || out_ch.ready;
  assign ld       = ctrl.out_load && out_free;

  assign gt      = rd_r.minute > min_r;
  assign take    = (idx_r == '0) || !gt;
  assign shift   = (idx_r != '0) && gt;
  assign idx_inc = (CNT_W + 1)'(idx_r) + (CNT_W + 1)'(1);
  assign empty   = cnt_r == '0;

  assign sp_sel  = empty ? stc_pkg::DEFAULT_SETPOINT : sp_r;
  assign on      = temp_r < sp_sel;
  assign changed = !last_valid_r || (last_on_r != on);

  assign flags.accept   = fire;
  assign flags.is_clear = cmd_r == stc_pkg::CMD_CLEAR;
  assign flags.is_add   = cmd_r == stc_pkg::CMD_ADD;
  assign flags.is_eval  = cmd_r == stc_pkg::CMD_EVAL;
  assign flags.full     = cnt_r == CNT_W'(MAX_ENTRIES);
  assign flags.empty    = empty;
  assign flags.scan_end = gt || (idx_inc == (CNT_W + 1)'(cnt_r));
  assign flags.shift    = shift;
  assign flags.out_busy = !out_free;

  always_comb begin
    case (ctrl.idx_op)
      stc_pkg::IDX_ZERO:      idx_nxt = '0;
      stc_pkg::IDX_CNT:       idx_nxt = IDX_W'(cnt_r);
      stc_pkg::IDX_INC:       idx_nxt = idx_r + IDX_W'(1);
      stc_pkg::IDX_SHIFT_DEC: idx_nxt = shift ? idx_r - IDX_W'(1) : idx_r;
      default:                idx_nxt = idx_r;
    endcase
  end

  // The read address follows the next index so that the entry it names is
  // already registered when the step that uses it runs.
  assign rd_addr = (ctrl.rd_sel == stc_pkg::RD_IDX_M1) ? idx_nxt - IDX_W'(1) : idx_nxt;

  always_comb begin
    case (ctrl.wr_op)
      stc_pkg::WR_SHIFT: begin
        wr_en   = shift;
        wr_data = rd_r;
      end
      stc_pkg::WR_NEW: begin
        wr_en          = 1'b1;
        wr_data.minute = min_r;
        wr_data.target = temp_r;
      end
      default: begin
        wr_en   = 1'b0;
        wr_data = rd_r;
      end
    endcase
  end

  always_comb begin
    case (ctrl.cnt_op)
      stc_pkg::CNT_CLEAR: cnt_nxt = '0;
      stc_pkg::CNT_INC:   cnt_nxt = cnt_r + CNT_W'(1);
      default:            cnt_nxt = cnt_r;
    endcase
  end

  always_comb begin
    last_valid_nxt = last_valid_r || ld;
    if (ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx_r] <= wr_data;
    end
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      last_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      cnt_r        <= cnt_nxt;
      last_valid_r <= last_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      cmd_r  <= in_ch.cmd;
      min_r  <= in_ch.minute_of_day;
      temp_r <= in_ch.temperature;
    end
    idx_r <= idx_nxt;
    if (ctrl.sp_take && take) begin
      sp_r <= rd_r.target;
    end
    if (ld) begin
      last_on_r        <= on;
      heater_on_r      <= on;
      heater_changed_r <= changed;
      setpoint_r       <= sp_sel;
      empty_r          <= empty;
    end
  end

  assign in_ch.ready           = ctrl.accept;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.heater_on      = heater_on_r;
  assign out_ch.heater_changed = heater_changed_r;
  assign out_ch.setpoint_used  = setpoint_r;
  assign out_ch.schedule_empty = empty_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry count above capacity");

  a_load_eval: assert property (@(posedge clk) disable iff (!rst_n)
    ld |-> cmd_r == stc_pkg::CMD_EVAL)
    else $error("result produced for a command other than evaluate");

  a_first_change: assert property (@(posedge clk) disable iff (!rst_n)
    ld && !last_valid_r |=> out_ch.heater_changed)
    else $error("first evaluation not flagged as a change");

endmodule

`default_nettype wire

// File: rtl/scheduled_thermostat_controller_top.sv
`default_nettype none

// Channel  Dir  Beat contents                                  Handshake
// in_ch    in   cmd, minute_of_day, temperature                valid/ready
// out_ch   out  heater_on, heater_changed, setpoint_used,      valid/ready
//               schedule_empty
//
// One command is in work at a time. A clear empties the schedule; an unused code and an add
// to a full schedule are dropped; any other add moves each entry later than its minute up
// one place and then writes the new entry; an evaluate reads entries in order until the
// scan stops, none when empty. The entry memory's one read port reads one entry per cycle.
// Synchronous reset empties the schedule and forgets the last decision; no clearing pass.
// A result beat waits in the output register; only a later evaluate stalls on it.

module scheduled_thermostat_controller_top #(
  parameter int MAX_ENTRIES = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  stc_in_if.sink    in_ch,
  stc_out_if.source out_ch
);

  stc_pkg::dp_ctrl_t ctrl;
  stc_pkg::flags_t   flags;

  // Sequencer: step counter plus the control store that drives the datapath.
  stc_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  // Datapath: entry memory, index and count registers, compare and result register.
  stc_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .ctrl   (ctrl),
    .flags  (flags)
  );

  // A command beat is never followed by another in the very next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted in back-to-back cycles");

endmodule

`default_nettype wire
